@@ rtl/trip_fuel_distance_accumulator_top_macros.svh @@
// Assertion helpers shared by the trip computer modules.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef TRIP_FUEL_DISTANCE_ACCUMULATOR_TOP_MACROS_SVH
`define TRIP_FUEL_DISTANCE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TFDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tfda_pkg.sv @@
`timescale 1ns / 1ps
package tfda_pkg;

  // Tick period and derived tick count per second.
  localparam int unsigned TICK_PERIOD_MS   = 50;
  localparam int unsigned TICKS_PER_SECOND = 1000 / TICK_PERIOD_MS;

  // Fixed-point units and limits.
  localparam int unsigned GRAM_ONE     = 65536;
  localparam int unsigned GRAM_SHIFT   = 16;
  localparam int unsigned METER_ONE    = 360000;
  localparam int unsigned GAP_LIMIT_US = 200000;
  localparam int unsigned US_PER_S     = 1000000;

  // Field widths.
  localparam int unsigned AMOUNT_W = 20;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned TICK_W   = 10;

  // Internal widths.
  localparam int unsigned GFRAC_W   = GRAM_SHIFT + 1;
  localparam int unsigned GSUM_W    = AMOUNT_W + 1;
  localparam int unsigned GCARRY_W  = GSUM_W - GRAM_SHIFT;
  localparam int unsigned MFRAC_W   =
    $clog2((2 ** SPEED_W - 1) * TICK_PERIOD_MS + METER_ONE + 1);
  localparam int unsigned GAP_W     = $clog2(GAP_LIMIT_US + 1);
  localparam int unsigned SCALE_W   = $clog2(US_PER_S + 1);
  localparam int unsigned PROD_W    = AMOUNT_W + SCALE_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

  // Request kinds; the remaining code leaves the state unchanged.
  typedef enum logic [1:0] {
    REQ_PULSE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [AMOUNT_W-1:0] fuel_amount;
    logic [TIME_W-1:0]   time_now_us;
    logic [SPEED_W-1:0]  speed_centi_kmh;
    logic                engine_running;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] consumed_grams;
    logic [TOTAL_W-1:0] fuel_rate;
    logic [TOTAL_W-1:0] distance_meters;
    logic [TOTAL_W-1:0] ignition_on_seconds;
    logic [TOTAL_W-1:0] engine_run_seconds;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic rate_write;
    logic mtr_step;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_en;
    logic mtr_more;
  } dp_sts_t;

endpackage

@@ rtl/tfda_ifs.sv @@
`timescale 1ns / 1ps
// Request channel into the trip computer.
interface tfda_in_if import tfda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [AMOUNT_W-1:0] fuel_amount;
  logic [TIME_W-1:0]   time_now_us;
  logic [SPEED_W-1:0]  speed_centi_kmh;
  logic                engine_running;

  modport source (
    output valid, req_type, fuel_amount, time_now_us, speed_centi_kmh, engine_running,
    input  ready
  );
  modport sink (
    input  valid, req_type, fuel_amount, time_now_us, speed_centi_kmh, engine_running,
    output ready
  );
endinterface

// Result channel out of the trip computer.
interface tfda_out_if import tfda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] consumed_grams;
  logic [TOTAL_W-1:0] fuel_rate;
  logic [TOTAL_W-1:0] distance_meters;
  logic [TOTAL_W-1:0] ignition_on_seconds;
  logic [TOTAL_W-1:0] engine_run_seconds;

  modport source (
    output valid, consumed_grams, fuel_rate, distance_meters, ignition_on_seconds,
           engine_run_seconds,
    input  ready
  );
  modport sink (
    input  valid, consumed_grams, fuel_rate, distance_meters, ignition_on_seconds,
           engine_run_seconds,
    output ready
  );
endinterface

@@ rtl/tfda_datapath.sv @@
`timescale 1ns / 1ps
`include "trip_fuel_distance_accumulator_top_macros.svh"
module tfda_datapath import tfda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output dp_sts_t    sts,
  output out_item_t  out_item
);

  // Trip state.
  logic [TOTAL_W-1:0] gram_total_r;
  logic [GFRAC_W-1:0] gram_frac_r;
  logic [TOTAL_W-1:0] meter_total_r;
  logic [MFRAC_W-1:0] mfrac_r;
  logic [TICK_W-1:0]  tick_r;
  logic [TOTAL_W-1:0] ign_sec_r;
  logic [TOTAL_W-1:0] run_sec_r;
  logic [TIME_W-1:0]  last_time_r;
  logic               pulse_seen_r;
  logic [TOTAL_W-1:0] rate_r;
  logic               div_en_r;

  // Rate working registers.
  logic [AMOUNT_W-1:0] amount_r;
  logic [GAP_W-1:0]    gap_r;
  logic [PROD_W-1:0]   dq_r;
  logic [GAP_W-1:0]    rem_r;

  out_item_t out_r;

  // Gram accumulation: carry whole grams while the fraction exceeds one gram.
  logic [GSUM_W-1:0]   gsum;
  logic [GSUM_W-1:0]   gsum_m1;
  logic [GCARRY_W-1:0] gcarry;
  logic [GFRAC_W-1:0]  gfrac_nxt;

  always_comb begin
    gsum    = GSUM_W'(gram_frac_r) + GSUM_W'(in_item.fuel_amount);
    gsum_m1 = gsum - GSUM_W'(1);
    if (gsum == '0) begin
      gcarry    = '0;
      gfrac_nxt = '0;
    end else begin
      gcarry    = gsum_m1[GSUM_W-1:GRAM_SHIFT];
      gfrac_nxt = GFRAC_W'(gsum_m1[GRAM_SHIFT-1:0]) + GFRAC_W'(1);
    end
  end

  // Pulse gap check decides whether a division is needed.
  logic [TIME_W-1:0] gap;
  logic              div_en_nxt;

  always_comb begin
    gap        = in_item.time_now_us - last_time_r;
    div_en_nxt = pulse_seen_r && (gap != '0) && (gap <= TIME_W'(GAP_LIMIT_US));
  end

  // Tick counter with wrap at one second.
  logic [TICK_W-1:0] tick_inc;
  logic              sec_wrap;

  always_comb begin
    tick_inc = tick_r + TICK_W'(1);
    sec_wrap = (tick_inc >= TICK_W'(TICKS_PER_SECOND));
  end

  // One restoring division step.
  logic [GAP_W:0]   div_trial;
  logic [GAP_W:0]   div_diff;
  logic             div_bit;

  always_comb begin
    div_trial = {rem_r, dq_r[PROD_W-1]};
    div_diff  = div_trial - {1'b0, gap_r};
    div_bit   = (div_trial >= {1'b0, gap_r});
  end

  // Trip state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gram_total_r  <= '0;
      gram_frac_r   <= '0;
      meter_total_r <= '0;
      mfrac_r       <= '0;
      tick_r        <= '0;
      ign_sec_r     <= '0;
      run_sec_r     <= '0;
      last_time_r   <= '0;
      pulse_seen_r  <= 1'b0;
      rate_r        <= '0;
      div_en_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        case (in_item.req_type)
          REQ_PULSE: begin
            gram_frac_r  <= gfrac_nxt;
            gram_total_r <= gram_total_r + TOTAL_W'(gcarry);
            last_time_r  <= in_item.time_now_us;
            pulse_seen_r <= 1'b1;
            div_en_r     <= div_en_nxt;
            if (!div_en_nxt) begin
              rate_r <= '0;
            end
          end
          REQ_TICK: begin
            mfrac_r <= mfrac_r
                       + MFRAC_W'(in_item.speed_centi_kmh) * MFRAC_W'(TICK_PERIOD_MS);
            if (sec_wrap) begin
              tick_r    <= '0;
              ign_sec_r <= ign_sec_r + TOTAL_W'(1);
              if (in_item.engine_running) begin
                run_sec_r <= run_sec_r + TOTAL_W'(1);
              end
            end else begin
              tick_r <= tick_inc;
            end
          end
          REQ_CLEAR: begin
            gram_total_r  <= '0;
            gram_frac_r   <= '0;
            meter_total_r <= '0;
            mfrac_r       <= '0;
            tick_r        <= '0;
            ign_sec_r     <= '0;
            run_sec_r     <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.mtr_step) begin
        mfrac_r       <= mfrac_r - MFRAC_W'(METER_ONE);
        meter_total_r <= meter_total_r + TOTAL_W'(1);
      end
      if (cmd.rate_write) begin
        rate_r <= (|dq_r[PROD_W-1:TOTAL_W]) ? '0 : dq_r[TOTAL_W-1:0];
      end
    end
  end

  // Rate working registers and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      amount_r <= in_item.fuel_amount;
      gap_r    <= GAP_W'(gap);
    end
    if (cmd.mul) begin
      dq_r  <= PROD_W'(amount_r) * PROD_W'(US_PER_S);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dq_r  <= {dq_r[PROD_W-2:0], div_bit};
      rem_r <= div_bit ? div_diff[GAP_W-1:0] : div_trial[GAP_W-1:0];
    end
    if (cmd.out_load) begin
      out_r.consumed_grams      <= gram_total_r;
      out_r.fuel_rate           <= rate_r;
      out_r.distance_meters     <= meter_total_r;
      out_r.ignition_on_seconds <= ign_sec_r;
      out_r.engine_run_seconds  <= run_sec_r;
    end
  end

  assign sts.div_en   = div_en_r;
  assign sts.mtr_more = (mfrac_r > MFRAC_W'(METER_ONE));
  assign out_item     = out_r;

  // Fractions are back in range whenever a result is captured.
  `TFDA_ASSERT_IMP(a_meter_frac, cmd.out_load, mfrac_r <= MFRAC_W'(METER_ONE), "meter fraction out of range at result")
  `TFDA_ASSERT_IMP(a_gram_frac, cmd.out_load, gram_frac_r <= GFRAC_W'(GRAM_ONE), "gram fraction out of range at result")
  `TFDA_ASSERT_NEXT(a_rate_zero, cmd.load && (in_item.req_type == REQ_PULSE) && !div_en_nxt, rate_r == '0, "rate not cleared for an unusable pulse gap")

endmodule

@@ rtl/tfda_ctrl.sv @@
`timescale 1ns / 1ps
`include "trip_fuel_distance_accumulator_top_macros.svh"
module tfda_ctrl import tfda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RATE,
    S_MTR,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (req_type_t'(req_type))
            REQ_PULSE: state_nxt = S_MUL;
            REQ_TICK:  state_nxt = S_MTR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = sts.div_en ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(PROD_W - 1)) begin
          div_cnt_nxt = '0;
          state_nxt   = S_RATE;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      S_RATE: begin
        cmd.rate_write = 1'b1;
        state_nxt      = S_DONE;
      end
      S_MTR: begin
        if (sts.mtr_more) begin
          cmd.mtr_step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // The step counter only moves during division; a waiting result is never dropped.
  `TFDA_ASSERT_IMP(a_cnt_idle, state_r != S_DIV, div_cnt_r == '0, "divider count active outside division")
  `TFDA_ASSERT_NEXT(a_tick_to_mtr, in_valid && in_ready && (req_type == REQ_TICK), state_r == S_MTR, "tick request did not enter meter carry")
  `TFDA_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r, "result dropped before it was taken")

endmodule

@@ rtl/trip_fuel_distance_accumulator_top.sv @@
// Trip computer: one result per request, with totals taken after the update.
// Pulse with a usable gap: result valid 43 cycles after acceptance, next request
// 44 cycles after it; the 40-step restoring rate divider sets this figure.
// Other pulses: result 2, next request 3; tick: 2 and 3 plus one per meter carried;
// clear and unknown: 1 and 2. A result held back by the sink delays the next one.
// Synchronous active-low reset zeroes all totals, rate and pulse timing at once.
`timescale 1ns / 1ps
module trip_fuel_distance_accumulator_top import tfda_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  tfda_in_if.sink    in_chan,
  tfda_out_if.source out_chan
);

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;

  // Gather the request fields.
  assign in_item.req_type        = in_chan.req_type;
  assign in_item.fuel_amount     = in_chan.fuel_amount;
  assign in_item.time_now_us     = in_chan.time_now_us;
  assign in_item.speed_centi_kmh = in_chan.speed_centi_kmh;
  assign in_item.engine_running  = in_chan.engine_running;

  tfda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .req_type  (in_chan.req_type),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tfda_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // Drive the result fields.
  assign out_chan.consumed_grams      = out_item.consumed_grams;
  assign out_chan.fuel_rate           = out_item.fuel_rate;
  assign out_chan.distance_meters     = out_item.distance_meters;
  assign out_chan.ignition_on_seconds = out_item.ignition_on_seconds;
  assign out_chan.engine_run_seconds  = out_item.engine_run_seconds;

endmodule
